>>> design/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> design/ssmmr_pkg.sv
package ssmmr_pkg;
  localparam int SampleBits = 13;
  localparam int MaxItems   = 524288;
  localparam int NBins      = 1 << SampleBits;
  localparam int CntBits    = 20;
  localparam int SumBits    = 33;
  localparam int DivBits    = 35;

  typedef logic [SampleBits-1:0] bin_idx_t;
  typedef logic [CntBits-1:0]    count_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_DRAIN,
    ST_WALK1,
    ST_WALK2,
    ST_DIV,
    ST_OUT
  } state_t;
endpackage

>>> design/set_statistics_mean_median_mode_range.sv
// Statistics of a sample set: mean (rounded half up), median (sorted index count/2), mode
// (second smallest of the tied most-frequent values, else the only one) and range. Samples
// load at one per cycle while in the load state into an 8192-entry histogram RAM
// (read-modify-write with forwarding). After the sample marked last, the load pipeline
// drains, the histogram is walked twice (one RAM read per cycle), then a bit-serial
// divider forms the mean; the result is then held until taken. The drain, walks, divide,
// output and a clearing pass of the histogram are repeated per set. After reset the same
// clearing pass runs before the first sample is taken.
`include "assert_macros.svh"
module set_statistics_mean_median_mode_range (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [ssmmr_pkg::SampleBits-1:0] in_sample,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [ssmmr_pkg::SampleBits-1:0] out_mean_rounded,
  output logic signed [ssmmr_pkg::SampleBits-1:0] out_median,
  output logic signed [ssmmr_pkg::SampleBits-1:0] out_mode,
  output logic [ssmmr_pkg::SampleBits-1:0] out_spread
);
  localparam int SB = ssmmr_pkg::SampleBits;
  localparam int CB = ssmmr_pkg::CntBits;
  localparam int DB = ssmmr_pkg::DivBits;

  ssmmr_pkg::state_t state_r, state_nxt;

  ssmmr_pkg::count_t hist_mem [ssmmr_pkg::NBins];
  ssmmr_pkg::count_t rd_data_r;
  ssmmr_pkg::bin_idx_t rd_addr, wr_addr;
  ssmmr_pkg::count_t wr_data;
  logic wr_en;

  ssmmr_pkg::bin_idx_t idx_r;       // sweep counter
  logic                sweep_done;

  // load pipeline: stage 1 holds bin being updated
  logic                p1_vld_r;
  ssmmr_pkg::bin_idx_t p1_idx_r;
  logic                p2_vld_r;
  ssmmr_pkg::bin_idx_t p2_idx_r;
  ssmmr_pkg::count_t   p2_data_r;
  // last written bin, still unseen by a read issued on its write edge
  logic                p3_vld_r;
  ssmmr_pkg::bin_idx_t p3_idx_r;
  ssmmr_pkg::count_t   p3_data_r;

  ssmmr_pkg::count_t        count_r;
  logic signed [ssmmr_pkg::SumBits-1:0] sum_r;
  logic signed [SB-1:0]     min_r, max_r;

  // walk
  logic                walk_vld_r;
  ssmmr_pkg::bin_idx_t walk_idx_r;
  ssmmr_pkg::count_t   cum_r, best_r;
  logic                found_r;
  logic [1:0]          nties_r;
  logic signed [SB-1:0] median_r, first_r, second_r;

  // divider (non-negative num, restoring)
  logic [DB-1:0] dnum_r, drem_r, dquo_r, dden_r;
  logic          dneg_r;
  logic [5:0]    dstep_r;

  logic accept_in;
  logic signed [SB-1:0] res_mean_r, res_median_r, res_mode_r;
  logic [SB-1:0] res_spread_r;

  assign accept_in  = in_valid && in_ready;
  assign sweep_done = (idx_r == ssmmr_pkg::bin_idx_t'(ssmmr_pkg::NBins - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssmmr_pkg::ST_CLEAR: if (sweep_done) state_nxt = ssmmr_pkg::ST_LOAD;
      ssmmr_pkg::ST_LOAD:  if (accept_in && in_last_item) state_nxt = ssmmr_pkg::ST_DRAIN;
      ssmmr_pkg::ST_DRAIN: if (!p1_vld_r && !p2_vld_r) state_nxt = ssmmr_pkg::ST_WALK1;
      ssmmr_pkg::ST_WALK1: if (sweep_done && walk_vld_r && walk_idx_r == idx_r)
        state_nxt = ssmmr_pkg::ST_WALK2;
      ssmmr_pkg::ST_WALK2: if (sweep_done && walk_vld_r && walk_idx_r == idx_r)
        state_nxt = ssmmr_pkg::ST_DIV;
      ssmmr_pkg::ST_DIV:   if (dstep_r == 6'd0) state_nxt = ssmmr_pkg::ST_OUT;
      ssmmr_pkg::ST_OUT:   if (out_ready) state_nxt = ssmmr_pkg::ST_CLEAR;
      default:             state_nxt = ssmmr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ssmmr_pkg::ST_LOAD);
    out_valid = (state_r == ssmmr_pkg::ST_OUT);
  end

  // RAM ports
  always_comb begin
    rd_addr = idx_r;
    if (state_r == ssmmr_pkg::ST_LOAD) rd_addr = in_sample ^ {1'b1, {(SB-1){1'b0}}};
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = '0;
    if (state_r == ssmmr_pkg::ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (p2_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = p2_idx_r;
      wr_data = p2_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[wr_addr] <= wr_data;
    rd_data_r <= hist_mem[rd_addr];
  end

  // old count for the increment, forwarded from the write stage and the last write
  ssmmr_pkg::count_t p1_old;
  always_comb begin
    priority if (p2_vld_r && p2_idx_r == p1_idx_r) begin
      p1_old = p2_data_r;
    end else if (p3_vld_r && p3_idx_r == p1_idx_r) begin
      p1_old = p3_data_r;
    end else begin
      p1_old = rd_data_r;
    end
  end

  logic signed [SB-1:0] walk_val;
  assign walk_val = walk_idx_r ^ {1'b1, {(SB-1){1'b0}}};

  logic [DB-1:0] num_abs, trial;
  logic signed [DB-1:0] num_s;
  assign num_s = DB'(sum_r) * 2 + DB'(count_r);
  assign num_abs = num_s[DB-1] ? DB'(-num_s) : DB'(num_s);
  assign trial = {drem_r[DB-2:0], dnum_r[DB-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ssmmr_pkg::ST_CLEAR;
      idx_r    <= '0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      walk_vld_r <= 1'b0;
      count_r  <= '0;
      sum_r    <= '0;
      min_r    <= {1'b0, {(SB-1){1'b1}}};
      max_r    <= {1'b1, {(SB-1){1'b0}}};
    end else begin
      state_r <= state_nxt;
      p1_vld_r <= 1'b0;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      walk_vld_r <= 1'b0;
      if (p1_vld_r) begin
        p2_idx_r  <= p1_idx_r;
        p2_data_r <= p1_old + 1'b1;
      end
      if (p2_vld_r) begin
        p3_idx_r  <= p2_idx_r;
        p3_data_r <= p2_data_r;
      end
      unique case (state_r)
        ssmmr_pkg::ST_CLEAR: begin
          idx_r   <= idx_r + 1'b1;
          count_r <= '0;
          sum_r   <= '0;
          min_r   <= {1'b0, {(SB-1){1'b1}}};
          max_r   <= {1'b1, {(SB-1){1'b0}}};
        end
        ssmmr_pkg::ST_LOAD: begin
          idx_r <= '0;
          if (accept_in && count_r < CB'(ssmmr_pkg::MaxItems)) begin
            p1_vld_r <= 1'b1;
            p1_idx_r <= in_sample ^ {1'b1, {(SB-1){1'b0}}};
            count_r  <= count_r + 1'b1;
            sum_r    <= sum_r + ssmmr_pkg::SumBits'(in_sample);
            if (in_sample < min_r) min_r <= in_sample;
            if (in_sample > max_r) max_r <= in_sample;
          end
          cum_r <= '0; best_r <= '0; found_r <= 1'b0; nties_r <= '0;
          median_r <= '0; first_r <= '0; second_r <= '0;
        end
        ssmmr_pkg::ST_DRAIN: idx_r <= '0;
        ssmmr_pkg::ST_WALK1, ssmmr_pkg::ST_WALK2: begin
          if (!(walk_vld_r && walk_idx_r == idx_r && sweep_done)) begin
            if (!(sweep_done && walk_vld_r)) begin
              walk_vld_r <= 1'b1;
              walk_idx_r <= idx_r;
              if (!sweep_done) idx_r <= idx_r + 1'b1;
            end
          end else begin
            idx_r <= '0;
          end
          if (walk_vld_r) begin
            if (state_r == ssmmr_pkg::ST_WALK1) begin
              cum_r <= cum_r + rd_data_r;
              if (!found_r && (cum_r + rd_data_r) > (count_r >> 1)) begin
                median_r <= walk_val;
                found_r  <= 1'b1;
              end
              if (rd_data_r > best_r) best_r <= rd_data_r;
            end else if (nties_r < 2'd2 && rd_data_r == best_r && best_r != '0) begin
              if (nties_r == 2'd0) first_r <= walk_val;
              else second_r <= walk_val;
              nties_r <= nties_r + 1'b1;
            end
          end
          dnum_r  <= num_abs;
          dneg_r  <= num_s[DB-1];
          dden_r  <= DB'(count_r) << 1;
          drem_r  <= '0;
          dquo_r  <= '0;
          dstep_r <= 6'(DB);
        end
        ssmmr_pkg::ST_DIV: begin
          if (dstep_r != 6'd0) begin
            dstep_r <= dstep_r - 1'b1;
            dnum_r  <= dnum_r << 1;
            if (trial >= dden_r) begin
              drem_r <= trial - dden_r;
              dquo_r <= {dquo_r[DB-2:0], 1'b1};
            end else begin
              drem_r <= trial;
              dquo_r <= {dquo_r[DB-2:0], 1'b0};
            end
          end else begin
            // floor for negative numerators
            res_mean_r <= dneg_r ? SB'(~dquo_r + ((drem_r == '0) ? 1'b1 : 1'b0))
                                 : SB'(dquo_r);
            res_median_r <= median_r;
            res_mode_r   <= (nties_r > 2'd1) ? second_r : first_r;
            res_spread_r <= SB'(max_r - min_r);
          end
          idx_r <= '0;
        end
        ssmmr_pkg::ST_OUT: idx_r <= '0;
        default: idx_r <= '0;
      endcase
    end
  end

  assign out_mean_rounded = res_mean_r;
  assign out_median       = res_median_r;
  assign out_mode         = res_mode_r;
  assign out_spread       = res_spread_r;

  `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `ASSERT_IMPLIES(a_count_cap, clk, rst_n, 1'b1, count_r <= ssmmr_pkg::MaxItems)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

>>> verif/testbench.sv
module testbench;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [12:0] in_sample;
  logic in_last_item;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [12:0] out_mean_rounded;
  logic signed [12:0] out_median;
  logic signed [12:0] out_mode;
  logic [12:0] out_spread;

  localparam int SetCap   = 524288;
  localparam int CycleMax = 12000000;

  typedef struct packed {
    logic signed [12:0] mean_rounded;
    logic signed [12:0] median;
    logic signed [12:0] mode;
    logic [12:0]        spread;
  } stats_t;

  class stats_scoreboard;
    int unsigned hist[8192];
    int unsigned count;
    longint      sum;
    int          lo;
    int          hi;
    stats_t      pending_stats[$];
    int          mismatches;
    int          results_seen;
    int          sets_closed;

    function new();
      clear_set();
      mismatches   = 0;
      results_seen = 0;
      sets_closed  = 0;
    endfunction

    function void clear_set();
      foreach (hist[i]) hist[i] = 0;
      count = 0;
      sum   = 0;
      lo    = 4095;
      hi    = -4096;
    endfunction

    // accepted input transaction
    function void note_sample(logic signed [12:0] s, bit last);
      int          v;
      longint      num, den, q;
      int unsigned cum, target, best, nties;
      int          med, first, second;
      bit          found;
      stats_t      e;
      v = s;
      if (count < SetCap) begin
        hist[v + 4096]++;
        count++;
        sum += v;
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      if (!last) return;
      num = 2 * sum + count;
      den = 2 * longint'(count);
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      target = count / 2;
      cum = 0; med = 0; best = 0; found = 1'b0;
      for (int i = 0; i < 8192; i++) begin
        cum += hist[i];
        if (!found && cum > target) begin
          med = i - 4096;
          found = 1'b1;
        end
        if (hist[i] > best) best = hist[i];
      end
      first = 0; second = 0; nties = 0;
      for (int i = 0; i < 8192 && nties < 2; i++) begin
        if (hist[i] == best && best != 0) begin
          if (nties == 0) first = i - 4096;
          else second = i - 4096;
          nties++;
        end
      end
      e.mean_rounded = q[12:0];
      e.median       = med[12:0];
      e.mode         = (nties > 1) ? second[12:0] : first[12:0];
      e.spread       = 13'(hi - lo);
      pending_stats.push_back(e);
      sets_closed++;
      clear_set();
    endfunction

    function void check_result(stats_t got);
      stats_t e;
      results_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mean %0d median %0d mode %0d spread %0d",
                   got.mean_rounded, got.median, got.mode, got.spread);
        return;
      end
      e = pending_stats.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp mean %0d median %0d mode %0d spread %0d, ",
                    "got mean %0d median %0d mode %0d spread %0d"},
                   e.mean_rounded, e.median, e.mode, e.spread,
                   got.mean_rounded, got.median, got.mode, got.spread);
      end
    endfunction
  endclass

  stats_scoreboard sb = new();

  int  cycles = 0;
  int  out_stall = 0;
  bit  quiet;           // no idling on either side while set
  int  items_sent;

  set_statistics_mean_median_mode_range u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_rounded (out_mean_rounded),
    .out_median       (out_median),
    .out_mode         (out_mode),
    .out_spread       (out_spread)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleMax) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_result({out_mean_rounded, out_median, out_mode, out_spread});
      out_stall <= quiet ? 0 : $urandom_range(9);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0 && !quiet) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // starts just after a posedge; returns at the accepting posedge
  task automatic send_sample(input logic signed [12:0] s, input bit last);
    int gap;
    gap = quiet ? 0 : $urandom_range(9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s, last);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set();
    int n, kind, centre, width, v;
    n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom_range(80, 4);
    kind = $urandom_range(3);
    centre = $urandom_range(8191) - 4096;
    width = $urandom_range(7);
    quiet = ($urandom_range(4) == 0);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = $urandom_range(8191) - 4096;
        1: v = centre + $urandom_range(width);
        2: v = $urandom_range(1) ? 4095 - $urandom_range(2) : -4096 + $urandom_range(2);
        default: v = centre + $urandom_range(40) - 20;
      endcase
      if (v > 4095) v = 4095;
      if (v < -4096) v = -4096;
      send_sample(v[12:0], i == n - 1);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_last_item = 1'b0;
    quiet        = 1'b0;
    items_sent   = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed sets: single extremes, full spread, ties, half rounding
    send_sample(-13'sd4096, 1'b1);
    send_sample(13'sd4095, 1'b1);
    send_sample(-13'sd4096, 1'b0);
    send_sample(13'sd4095, 1'b1);
    send_sample(13'sd3, 1'b0);
    send_sample(13'sd3, 1'b0);
    send_sample(-13'sd5, 1'b0);
    send_sample(-13'sd5, 1'b0);
    send_sample(13'sd7, 1'b0);
    send_sample(13'sd7, 1'b1);
    send_sample(-13'sd1, 1'b0);
    send_sample(13'sd0, 1'b1);
    send_sample(-13'sd2, 1'b0);
    send_sample(-13'sd1, 1'b1);
    send_sample(13'sd1, 1'b0);
    send_sample(13'sd2, 1'b0);
    send_sample(13'sd2, 1'b0);
    send_sample(-13'sd1, 1'b0);
    send_sample(13'sd0, 1'b1);
    hold_until_drained();

    // random sets
    for (int s = 0; s < 50; s++) begin
      send_random_set();
      if (s == 12) hold_until_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
    repeat (30000) @(posedge clk);

    $display("%0d samples in %0d sets, with random idling on both sides and bursts;",
             items_sent, sb.sets_closed);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_stats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
